FILE: hw/rtl/scrolling_tilemap_pixel_renderer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tile background renderer
// Shared property forms used by the RTL assertion sections.
// ----------------------------------------------------------------------------
`ifndef SCROLLING_TILEMAP_PIXEL_RENDERER_TOP_ASSERT_SVH
`define SCROLLING_TILEMAP_PIXEL_RENDERER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define STM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define STM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/stm_pkg.sv
// ----------------------------------------------------------------------------
// stm_pkg
// Types and constants shared by the tile background renderer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stm_pkg;

    // Transaction kinds
    typedef enum logic [1:0] {
        OP_MAP_WR = 2'd0,
        OP_PAT_WR = 2'd1,
        OP_RENDER = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Configuration register indexes
    localparam logic CFG_MAP_WIDTH = 1'b0;
    localparam logic CFG_PLAYER_X  = 1'b1;

    localparam int MW_W       = 9;    // map width register
    localparam int PX_W       = 18;   // player X register
    localparam int DIVIDEND_W = 13;   // wrapped column dividend
    localparam int DIV_STEPS  = 13;   // one quotient bit per stage
    localparam int MAP_IDX_W  = 16;   // widest map index
    localparam int PAT_IDX_W  = 13;
    localparam int PIX_W      = 17;
    localparam int CAM_OFFSET = 160;

    // Item carried down the pipeline
    typedef struct packed {
        t_op                    op;
        logic [MAP_IDX_W-1:0]   map_addr;
        logic [PAT_IDX_W-1:0]   pat_addr;
        logic [7:0]             wdata;
        logic [3:0]             row;
        logic [3:0]             ly;
        logic [3:0]             lx;
        logic [PIX_W-1:0]       pix;
    } t_item;

endpackage

`default_nettype wire

FILE: hw/rtl/stm_ram.sv
// ----------------------------------------------------------------------------
// stm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module stm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/stm_colwrap.sv
// ----------------------------------------------------------------------------
// stm_colwrap
// Pipelined restoring remainder: wraps a tile column modulo the map width.
// ----------------------------------------------------------------------------
`default_nettype none

module stm_colwrap (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [stm_pkg::MW_W-1:0]        i_mw,
    input  wire logic                            i_valid,
    input  wire stm_pkg::t_item                  i_item,
    input  wire logic [stm_pkg::DIVIDEND_W-1:0]  i_dividend,
    output logic                                 o_valid,
    output stm_pkg::t_item                       o_item,
    output logic      [stm_pkg::MW_W-1:0]        o_col
);
    import stm_pkg::*;

    localparam int TRIAL_W = MW_W + DIV_STEPS;

    logic                  r_vld  [DIV_STEPS];
    t_item                 r_item [DIV_STEPS];
    logic [DIVIDEND_W-1:0] r_rem  [DIV_STEPS];
    logic [DIVIDEND_W-1:0] n_rem  [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        localparam int SH = DIV_STEPS - 1 - s;
        logic [DIVIDEND_W-1:0] rem_in;
        logic [TRIAL_W-1:0]    trial;
        logic                  vld_in;
        t_item                 item_in;

        // Take the previous stage or the input
        if (s == 0) begin : g_first
            assign rem_in  = i_dividend;
            assign vld_in  = i_valid;
            assign item_in = i_item;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign vld_in  = r_vld[s-1];
            assign item_in = r_item[s-1];
        end

        // Subtract the shifted width where it fits
        assign trial = TRIAL_W'(i_mw) << SH;
        always_comb begin
            n_rem[s] = rem_in;
            if (TRIAL_W'(rem_in) >= trial) begin
                n_rem[s] = rem_in - trial[DIVIDEND_W-1:0];
            end
        end

        // Advance the stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
            r_rem[s]  <= n_rem[s];
            r_item[s] <= item_in;
        end
    end

    assign o_valid = r_vld[DIV_STEPS-1];
    assign o_item  = r_item[DIV_STEPS-1];
    assign o_col   = r_rem[DIV_STEPS-1][MW_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/scrolling_tilemap_pixel_renderer_top.sv
// ----------------------------------------------------------------------------
// scrolling_tilemap_pixel_renderer_top
// Horizontally scrolling 16x16-doubled tile background pixel renderer.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at each clock edge with start high; busy stays low,
//   so one transaction per cycle is taken with no gaps.
//   Kind 0 writes a tile map entry, kind 1 writes a pattern byte, kind 2
//   renders one pixel. Kind 3 and off-screen pixels are dropped.
//   A rendered pixel leaves on o_shade and o_pixel_address with o_strobe
//   high for one cycle, after stages A, B, the wrap, M, T, Q and output.
//   The receiver cannot stall; results leave in transaction order.
//   Throughput is one pixel per clock: the column wrap runs through a
//   13-stage remainder pipeline, and the map and pattern memories each see
//   one read or one write per cycle at a fixed pipeline stage, so writes
//   and reads keep their transaction order without forwarding.
//   Configuration: i_cfg_we with i_cfg_index 0 sets the map width (0 acts
//   as 1), index 1 sets the player X. Write only while no pixel is in flight.
//   Reset restores map width 20 and player X 0 and empties the pipeline;
//   memory contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module scrolling_tilemap_pixel_renderer_top #(
    parameter int MAP_DEPTH     = 4096,
    parameter int PATTERN_BYTES = 8192,
    parameter int SCREEN_WIDTH  = 320,
    parameter int TILE_ROWS     = 15
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [11:0] i_map_index,
    input  wire logic [12:0] i_pattern_index,
    input  wire logic [7:0]  i_write_value,
    input  wire logic [8:0]  i_screen_x,
    input  wire logic [7:0]  i_screen_y,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [17:0] i_cfg_wdata,
    output logic             o_strobe,
    output logic [3:0]       o_shade,
    output logic [16:0]      o_pixel_address
);
    import stm_pkg::*;

    `include "scrolling_tilemap_pixel_renderer_top_assert.svh"

    localparam int MAP_AW = $clog2(MAP_DEPTH);
    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam logic [10:0] SW_L = 11'(SCREEN_WIDTH);
    localparam logic [6:0]  TR_L = 7'(TILE_ROWS);

    // Configuration registers
    logic [MW_W-1:0] r_map_width;
    logic [PX_W-1:0] r_player_x;
    logic [MW_W-1:0] mw_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width <= MW_W'(20);
            r_player_x  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAP_WIDTH: r_map_width <= i_cfg_wdata[MW_W-1:0];
                CFG_PLAYER_X:  r_player_x  <= i_cfg_wdata;
                default:       r_map_width <= r_map_width;
            endcase
        end
    end

    assign mw_eff = (r_map_width == '0) ? MW_W'(1) : r_map_width;
    assign busy   = 1'b0;

    // Decode the transaction and drop what gives no result
    t_op                  in_op;
    logic                 in_keep;
    t_item                in_item;
    logic signed [17:0]   in_wx;
    logic [18:0]          in_pix;

    always_comb begin
        in_op   = t_op'(i_kind);
        in_keep = 1'b0;
        case (in_op)
            OP_MAP_WR, OP_PAT_WR: in_keep = 1'b1;
            OP_RENDER: in_keep = ({2'b00, i_screen_x} < SW_L) &&
                                 ({3'b000, i_screen_y[7:4]} < TR_L);
            default:   in_keep = 1'b0;
        endcase
        in_wx  = $signed({2'b00, r_player_x[PX_W-1:2]}) + $signed({9'd0, i_screen_x})
                 - 18'sd160;
        in_pix = 19'(i_screen_y) * 19'(SW_L) + 19'(i_screen_x);
        in_item.op       = in_op;
        in_item.map_addr = MAP_IDX_W'(i_map_index);
        in_item.pat_addr = i_pattern_index;
        in_item.wdata    = i_write_value;
        in_item.row      = i_screen_y[7:4];
        in_item.ly       = i_screen_y[3:0];
        in_item.lx       = in_wx[3:0];
        in_item.pix      = in_pix[PIX_W-1:0];
    end

    // Stage A: world X
    logic               r_a_vld;
    t_item              r_a_item;
    logic signed [17:0] r_a_wx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy && in_keep;
        end
        r_a_item <= in_item;
        r_a_wx   <= in_wx;
    end

    // Stage B: floor column, lifted non-negative by sixteen map widths
    logic                  r_b_vld;
    t_item                 r_b_item;
    logic [DIVIDEND_W-1:0] r_b_div;
    logic signed [13:0]    b_col;
    logic [14:0]           b_sum;

    always_comb begin
        b_col = r_a_wx[17:4];
        b_sum = 15'(b_col);
        if (b_col < 0) begin
            b_sum = 15'(b_col) + {2'b00, mw_eff, 4'b0000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_item <= r_a_item;
        r_b_div  <= b_sum[DIVIDEND_W-1:0];
    end

    // Wrap the column
    logic            cw_vld;
    t_item           cw_item;
    logic [MW_W-1:0] cw_col;

    stm_colwrap u_colwrap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mw       (mw_eff),
        .i_valid    (r_b_vld),
        .i_item     (r_b_item),
        .i_dividend (r_b_div),
        .o_valid    (cw_vld),
        .o_item     (cw_item),
        .o_col      (cw_col)
    );

    // Stage M: map entry address
    logic                 r_m_vld;
    t_item                r_m_item;
    logic [MAP_IDX_W-1:0] r_m_addr;
    logic [MAP_IDX_W-1:0] m_midx;

    assign m_midx = MAP_IDX_W'(cw_item.row) * MAP_IDX_W'(mw_eff) + MAP_IDX_W'(cw_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= cw_vld;
        end
        r_m_item <= cw_item;
        r_m_addr <= (cw_item.op == OP_MAP_WR) ? cw_item.map_addr : m_midx;
    end

    // Tile map access
    logic       map_we;
    logic       map_re;
    logic [7:0] map_rdata;

    assign map_we = r_m_vld && (r_m_item.op == OP_MAP_WR);
    assign map_re = r_m_vld && (r_m_item.op == OP_RENDER);

    stm_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (r_m_addr[MAP_AW-1:0]),
        .i_wdata (r_m_item.wdata),
        .i_re    (map_re),
        .i_raddr (r_m_addr[MAP_AW-1:0]),
        .o_rdata (map_rdata)
    );

    // Stage T: tile id ready, pattern access
    logic     r_t_vld;
    t_item    r_t_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else begin
            r_t_vld <= r_m_vld;
        end
        r_t_item <= r_m_item;
    end

    logic                 pat_we;
    logic                 pat_re;
    logic [PAT_IDX_W-1:0] pat_raddr;
    logic [7:0]           pat_rdata;

    assign pat_we    = r_t_vld && (r_t_item.op == OP_PAT_WR);
    assign pat_re    = r_t_vld && (r_t_item.op == OP_RENDER);
    assign pat_raddr = {map_rdata, r_t_item.ly[3:1], r_t_item.lx[3:2]};

    stm_ram #(
        .WIDTH (8),
        .DEPTH (PATTERN_BYTES)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (r_t_item.pat_addr[PAT_AW-1:0]),
        .i_wdata (r_t_item.wdata),
        .i_re    (pat_re),
        .i_raddr (pat_raddr[PAT_AW-1:0]),
        .o_rdata (pat_rdata)
    );

    // Stage Q: pattern byte ready
    logic             r_q_vld;
    logic             r_q_right;
    logic [PIX_W-1:0] r_q_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else begin
            r_q_vld <= pat_re;
        end
        r_q_right <= r_t_item.lx[1];
        r_q_pix   <= r_t_item.pix;
    end

    // Output register: pick the texel nibble
    logic             r_strobe;
    logic [3:0]       r_shade;
    logic [PIX_W-1:0] r_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_q_vld;
        end
        r_shade <= r_q_right ? pat_rdata[3:0] : pat_rdata[7:4];
        r_pix   <= r_q_pix;
    end

    assign o_strobe        = r_strobe;
    assign o_shade         = r_shade;
    assign o_pixel_address = r_pix;

    // Assertions
    `STM_ASSERT_NOW(a_col_wrapped, i_clk, i_rst_n, cw_vld, cw_col < mw_eff,
        "wrapped column not below map width")
    `STM_ASSERT_NOW(a_map_one_access, i_clk, i_rst_n, 1'b1, !(map_we && map_re),
        "map memory written and read in one cycle")
    `STM_ASSERT_NEXT(a_render_reaches_out, i_clk, i_rst_n, pat_re, r_q_vld,
        "pattern read lost before output")
    `STM_ASSERT_NOW(a_strobe_from_render, i_clk, i_rst_n, o_strobe, $past(r_q_vld),
        "result strobe without a rendered pixel")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Tile background renderer testbench
// Loads tile map and pattern entries, renders pixels under several map widths
// and camera positions, and checks every shade and frame buffer address
// against an in-bench model of the scrolled, doubled tile background.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stm_pkg::*;

    localparam int MAP_ENTRIES = 4096;
    localparam int PAT_ENTRIES = 8192;
    localparam int SCR_W       = 320;
    localparam int SCR_ROWS    = 15;
    localparam int DRAIN_WAIT  = 30;

    // Shadow of the renderer: memories, registers and pixels still due
    class render_scoreboard;
        typedef struct {
            bit [3:0]  shade;
            bit [16:0] addr;
        } pixel_t;

        bit [7:0]  tile_map [MAP_ENTRIES];
        bit [7:0]  patterns [PAT_ENTRIES];
        bit        map_ok   [MAP_ENTRIES];
        bit        pat_ok   [PAT_ENTRIES];
        bit [8:0]  width_reg = 9'd20;
        bit [17:0] player_x  = 18'd0;
        pixel_t    due [$];
        int        errors    = 0;

        function void set_reg(logic idx, bit [17:0] v);
            if (idx == CFG_MAP_WIDTH)
                width_reg = v[8:0];
            else
                player_x = v;
        endfunction

        function int world_x(int sx);
            return int'(player_x >> 2) - CAM_OFFSET + sx;
        endfunction

        // Map entry under a screen pixel, column wrapped into the map width
        function int map_addr(int sx, int sy);
            int mw;
            int wx;
            int col;
            mw = (width_reg == 0) ? 1 : int'(width_reg);
            wx = world_x(sx);
            col = (wx >= 0) ? wx / 16 : -((-wx + 15) / 16);
            col = col % mw;
            if (col < 0)
                col += mw;
            return ((sy >> 4) * mw + col) % MAP_ENTRIES;
        endfunction

        // Pattern byte under a screen pixel; needs its map entry loaded
        function int pat_addr(int sx, int sy);
            int lx;
            int ly;
            int tile;
            lx = world_x(sx) & 15;
            ly = sy & 15;
            tile = tile_map[map_addr(sx, sy)];
            return (tile * 32 + (ly >> 1) * 4 + (lx >> 2)) % PAT_ENTRIES;
        endfunction

        // Apply one accepted transaction and queue the pixel it yields
        function void note(t_op k, int mi, int pi, bit [7:0] wv, int sx, int sy);
            pixel_t p;
            bit [7:0] b;
            case (k)
                OP_MAP_WR: begin
                    tile_map[mi] = wv;
                    map_ok[mi] = 1'b1;
                end
                OP_PAT_WR: begin
                    patterns[pi] = wv;
                    pat_ok[pi] = 1'b1;
                end
                OP_RENDER: begin
                    if (sx < SCR_W && (sy >> 4) < SCR_ROWS) begin
                        b = patterns[pat_addr(sx, sy)];
                        p.shade = (world_x(sx) & 2) ? b[3:0] : b[7:4];
                        p.addr = 17'(sy * SCR_W + sx);
                        due.push_back(p);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check(bit [3:0] shade, bit [16:0] addr);
            pixel_t p;
            if (due.size() == 0) begin
                $display("%0t: unexpected pixel shade=%0d addr=%0d", $time, shade, addr);
                errors++;
                return;
            end
            p = due.pop_front();
            if (shade !== p.shade) begin
                $display("%0t: shade expected %0d actual %0d (addr %0d)",
                         $time, p.shade, shade, p.addr);
                errors++;
            end
            if (addr !== p.addr) begin
                $display("%0t: pixel_address expected %0d actual %0d",
                         $time, p.addr, addr);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_kind;
    logic [11:0] i_map_index;
    logic [12:0] i_pattern_index;
    logic [7:0]  i_write_value;
    logic [8:0]  i_screen_x;
    logic [7:0]  i_screen_y;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [17:0] i_cfg_wdata;
    logic        o_strobe;
    logic [3:0]  o_shade;
    logic [16:0] o_pixel_address;

    render_scoreboard sb = new();
    bit steady;

    scrolling_tilemap_pixel_renderer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_map_index     (i_map_index),
        .i_pattern_index (i_pattern_index),
        .i_write_value   (i_write_value),
        .i_screen_x      (i_screen_x),
        .i_screen_y      (i_screen_y),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_strobe        (o_strobe),
        .o_shade         (o_shade),
        .o_pixel_address (o_pixel_address)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Check each pixel as it leaves
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check(o_shade, o_pixel_address);
    end

    // Drive one transaction and hold it until taken; leaves start high
    task automatic send(t_op k, int mi, int pi, bit [7:0] wv, int sx, int sy);
        start           <= 1'b1;
        i_kind          <= k;
        i_map_index     <= 12'(mi);
        i_pattern_index <= 13'(pi);
        i_write_value   <= wv;
        i_screen_x      <= 9'(sx);
        i_screen_y      <= 8'(sy);
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sb.note(k, mi, pi, wv, sx, sy);
    endtask

    // Drop start for a random gap, mostly short, sometimes long
    task automatic pause();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = steady ? 0 : (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3)
                                                 : $urandom_range(5, 40);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic map_write(int mi, bit [7:0] wv);
        send(OP_MAP_WR, mi, $urandom, wv, $urandom, $urandom);
        pause();
    endtask

    task automatic pat_write(int pi, bit [7:0] wv);
        send(OP_PAT_WR, $urandom, pi, wv, $urandom, $urandom);
        pause();
    endtask

    // Render a pixel, loading its map entry and pattern byte first if unset
    task automatic render(int sx, int sy);
        int a;
        if (sx < SCR_W && (sy >> 4) < SCR_ROWS) begin
            a = sb.map_addr(sx, sy);
            if (!sb.map_ok[a])
                map_write(a, 8'($urandom));
            a = sb.pat_addr(sx, sy);
            if (!sb.pat_ok[a])
                pat_write(a, 8'($urandom));
        end
        send(OP_RENDER, $urandom, $urandom, 8'($urandom), sx, sy);
        pause();
    endtask

    // Hold until every pixel is out, then let trailing writes settle
    task automatic drain();
        start <= 1'b0;
        while (sb.due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_regs(bit [17:0] mw, bit [17:0] px);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAP_WIDTH;
        i_cfg_wdata <= mw;
        @(posedge i_clk);
        sb.set_reg(CFG_MAP_WIDTH, mw);
        i_cfg_index <= CFG_PLAYER_X;
        i_cfg_wdata <= px;
        @(posedge i_clk);
        sb.set_reg(CFG_PLAYER_X, px);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_items(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 60)
                render($urandom_range(0, SCR_W - 1), $urandom_range(0, 239));
            else if (r < 65)
                render($urandom_range(SCR_W, 511), $urandom_range(0, 255));
            else if (r < 68)
                render($urandom_range(0, 511), $urandom_range(240, 255));
            else if (r < 80)
                map_write($urandom_range(0, MAP_ENTRIES - 1), 8'($urandom));
            else if (r < 92)
                pat_write($urandom_range(0, PAT_ENTRIES - 1), 8'($urandom));
            else begin
                send(OP_NONE, $urandom, $urandom, 8'($urandom), $urandom, $urandom);
                pause();
            end
        end
    endtask

    initial begin
        bit [17:0] mws [7];
        bit [17:0] pxs [7];
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_kind          <= OP_NONE;
        i_map_index     <= '0;
        i_pattern_index <= '0;
        i_write_value   <= '0;
        i_screen_x      <= '0;
        i_screen_y      <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_MAP_WIDTH;
        i_cfg_wdata     <= '0;
        steady = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset registers, camera left of world origin
        map_write(0, 8'h00);
        map_write(MAP_ENTRIES - 1, 8'hFF);
        pat_write(0, 8'hFF);
        pat_write(PAT_ENTRIES - 1, 8'h00);
        render(0, 0);
        render(1, 0);
        render(2, 0);
        render(SCR_W - 1, 239);
        render(159, 100);
        render(160, 100);
        render(SCR_W, 0);
        render(511, 0);
        render(0, 240);
        render(511, 255);
        send(OP_NONE, MAP_ENTRIES - 1, PAT_ENTRIES - 1, 8'hFF, 511, 255);
        pause();
        drain();

        // Zero width acts as one, then both extremes of the camera
        mws = '{18'd0, 18'd1, 18'd256, 18'd511, 18'd20, 18'd0, 18'd0};
        pxs = '{18'd0, 18'h3FFFF, 18'd640, 18'd0, 18'd1000, 18'd0, 18'd0};
        mws[5] = 18'($urandom_range(1, 256));
        pxs[5] = 18'($urandom);
        mws[6] = 18'($urandom_range(1, 40));
        pxs[6] = 18'($urandom_range(0, 2000));
        pxs[3] = 18'($urandom);
        for (int p = 0; p < 7; p++) begin
            write_regs(mws[p], pxs[p]);
            render(0, 0);
            render(SCR_W - 1, 239);
            random_items(60);
            drain();
        end

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+hw/rtl
hw/rtl/stm_pkg.sv
hw/rtl/stm_ram.sv
hw/rtl/stm_colwrap.sv
hw/rtl/scrolling_tilemap_pixel_renderer_top.sv
tb/sv/tb.sv
